>>> design/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned TYPE_W        = 8;
  localparam int unsigned PRIO_W        = 64;
  localparam int unsigned COUNT_OUT_W   = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [TYPE_W-1:0]        atype;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } ctrl_t;

endpackage

`default_nettype wire

>>> design/spq_cell.sv
`default_nettype none

module spq_cell (
  input  wire logic           clk,
  input  wire spq_pkg::ctrl_t ctrl,
  input  wire logic           occupied,
  input  wire logic           left_keep,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t     entry,
  output logic                keep
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  assign keep  = occupied && ($signed(entry_r.prio) >= $signed(ctrl.new_entry.prio));
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> design/sorted_priority_queue.sv
// Channel | Ports                                                       | Handshake
// request | in_func, in_peer_address, in_peer_address_type, in_priority_req | start && !busy
// result  | out_ok, out_address*, out_priority, out_now_*, out_entry_count | out_valid, 1 cycle
// Busy stays low, so a request may follow every cycle.
// The result appears on the cycle after its request, held for exactly one cycle.
// Each slot cell compares its priority with the new one and shifts in one step.
// Reset clears the entry count and the result strobe; slot contents need no reset.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_func,
  input  wire logic [spq_pkg::ADDR_W-1:0]        in_peer_address,
  input  wire logic [spq_pkg::TYPE_W-1:0]        in_peer_address_type,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                                   out_valid,
  output logic                                   out_ok,
  output logic [spq_pkg::ADDR_W-1:0]             out_address,
  output logic [spq_pkg::TYPE_W-1:0]             out_address_type,
  output logic signed [spq_pkg::PRIO_W-1:0]      out_priority,
  output logic                                   out_now_empty,
  output logic                                   out_now_full,
  output logic [spq_pkg::COUNT_OUT_W-1:0]        out_entry_count
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_ok_r;
  spq_pkg::entry_t  out_entry_r;
  spq_pkg::entry_t  out_entry_nxt;
  logic             out_empty_r;
  logic             out_full_r;
  logic [spq_pkg::COUNT_OUT_W-1:0] out_count_r;
  logic [31:0]      count_ext;

  logic             accept;
  logic             ins_ok;
  logic             rem_ok;
  spq_pkg::ctrl_t   ctrl;

  spq_pkg::entry_t  cell_entry [QUEUE_DEPTH];
  logic             cell_keep  [QUEUE_DEPTH];
  logic             cell_occ   [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign ins_ok = accept && (in_func == spq_pkg::FUNC_INSERT) &&
                  (count_r < CNT_W'(QUEUE_DEPTH));
  assign rem_ok = accept && (in_func == spq_pkg::FUNC_REMOVE) && (count_r != '0);

  assign ctrl.ins             = ins_ok;
  assign ctrl.rem             = rem_ok;
  assign ctrl.new_entry.addr  = in_peer_address;
  assign ctrl.new_entry.atype = in_peer_address_type;
  assign ctrl.new_entry.prio  = in_priority_req;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_k;

      assign cell_occ[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_first
        assign left_e = '0;
        assign left_k = 1'b1;
      end else begin : g_mid
        assign left_e = cell_entry[gi-1];
        assign left_k = cell_keep[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_nlast
        assign right_e = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (cell_occ[gi]),
        .left_keep   (left_k),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry       (cell_entry[gi]),
        .keep        (cell_keep[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign out_entry_nxt = rem_ok ? cell_entry[0] : '0;
  assign count_ext     = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r    <= ins_ok || rem_ok;
      out_entry_r <= out_entry_nxt;
      out_empty_r <= (count_nxt == '0);
      out_full_r  <= (count_nxt >= CNT_W'(QUEUE_DEPTH));
      out_count_r <= count_ext[spq_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_address      = out_entry_r.addr;
  assign out_address_type = out_entry_r.atype;
  assign out_priority     = out_entry_r.prio;
  assign out_now_empty    = out_empty_r;
  assign out_now_full     = out_full_r;
  assign out_entry_count  = out_count_r;

endmodule

`default_nettype wire

>>> design/spq_checker.sv
`default_nettype none

module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              out_valid,
  input wire logic                              out_ok,
  input wire logic [spq_pkg::ADDR_W-1:0]        out_address,
  input wire logic [spq_pkg::TYPE_W-1:0]        out_address_type,
  input wire logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  input wire logic                              out_now_empty,
  input wire logic                              out_now_full,
  input wire logic [spq_pkg::COUNT_OUT_W-1:0]   out_entry_count
);

  localparam logic [spq_pkg::COUNT_OUT_W-1:0] DEPTH_SHOWN =
    spq_pkg::COUNT_OUT_W'(QUEUE_DEPTH);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> out_valid)
    else $error("request accepted without a result on the next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(start && !busy)) |=> !out_valid)
    else $error("result strobe without an accepted request");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |->
      (out_address == '0 && out_address_type == '0 && out_priority == '0))
    else $error("refused request returned a nonzero entry");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_now_empty) |-> (out_entry_count == '0 && !out_now_full))
    else $error("empty flag disagrees with the count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_now_full) |-> (out_entry_count == DEPTH_SHOWN))
    else $error("full flag disagrees with the count");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_address      (out_address),
  .out_address_type (out_address_type),
  .out_priority     (out_priority),
  .out_now_empty    (out_now_empty),
  .out_now_full     (out_now_full),
  .out_entry_count  (out_entry_count)
);

`default_nettype wire

>>> test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int unsigned QDEPTH = spq_pkg::DEPTH_DEFAULT;
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RAND_ITEMS = 1600;
  localparam int unsigned QUIET_TAIL = 200;
  localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MAX =
    {1'b0, {(spq_pkg::PRIO_W-1){1'b1}}};
  localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MIN =
    {1'b1, {(spq_pkg::PRIO_W-1){1'b0}}};

  typedef struct packed {
    logic                              ok;
    logic [spq_pkg::ADDR_W-1:0]        addr;
    logic [spq_pkg::TYPE_W-1:0]        atype;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic                              empty;
    logic                              full;
    logic [spq_pkg::COUNT_OUT_W-1:0]   count;
  } reply_t;

  typedef struct {
    logic            func;
    spq_pkg::entry_t item;
    logic            fixed;
    reply_t          fixed_reply;
  } step_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              in_func = spq_pkg::FUNC_INSERT;
  logic [spq_pkg::ADDR_W-1:0]        in_peer_address = '0;
  logic [spq_pkg::TYPE_W-1:0]        in_peer_address_type = '0;
  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req = '0;
  logic                              req_fixed = 1'b0;
  reply_t                            req_fixed_reply = '0;

  logic                              busy;
  logic                              out_valid;
  logic                              out_ok;
  logic [spq_pkg::ADDR_W-1:0]        out_address;
  logic [spq_pkg::TYPE_W-1:0]        out_address_type;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority;
  logic                              out_now_empty;
  logic                              out_now_full;
  logic [spq_pkg::COUNT_OUT_W-1:0]   out_entry_count;

  spq_pkg::entry_t shadow_slots [QDEPTH];
  int unsigned     shadow_count = 0;
  reply_t          awaited_replies [$];
  int unsigned     error_count = 0;
  step_t           directed_rows [DIRECTED_ROWS];

  sorted_priority_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_peer_address     (in_peer_address),
    .in_peer_address_type(in_peer_address_type),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_ok              (out_ok),
    .out_address         (out_address),
    .out_address_type    (out_address_type),
    .out_priority        (out_priority),
    .out_now_empty       (out_now_empty),
    .out_now_full        (out_now_full),
    .out_entry_count     (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic reply_t make_reply(logic ok, logic [spq_pkg::ADDR_W-1:0] addr,
                                        logic [spq_pkg::TYPE_W-1:0] atype,
                                        logic signed [spq_pkg::PRIO_W-1:0] prio,
                                        logic empty, logic full,
                                        logic [spq_pkg::COUNT_OUT_W-1:0] count);
    reply_t r;
    r.ok = ok;
    r.addr = addr;
    r.atype = atype;
    r.prio = prio;
    r.empty = empty;
    r.full = full;
    r.count = count;
    return r;
  endfunction

  function automatic step_t make_step(logic func, logic [spq_pkg::ADDR_W-1:0] addr,
                                      logic [spq_pkg::TYPE_W-1:0] atype,
                                      logic signed [spq_pkg::PRIO_W-1:0] prio,
                                      logic fixed, reply_t fixed_reply);
    step_t s;
    s.func = func;
    s.item.addr = addr;
    s.item.atype = atype;
    s.item.prio = prio;
    s.fixed = fixed;
    s.fixed_reply = fixed_reply;
    return s;
  endfunction

  // An insert goes behind every held entry of greater or equal priority.
  function automatic reply_t apply_queue_op(logic func, spq_pkg::entry_t item);
    reply_t      r;
    int unsigned pos;
    int unsigned i;
    r = '0;
    if (func == spq_pkg::FUNC_INSERT) begin
      if (shadow_count < QDEPTH) begin
        pos = 0;
        while (pos < shadow_count &&
               $signed(shadow_slots[pos].prio) >= $signed(item.prio)) pos++;
        for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = item;
        shadow_count++;
        r.ok = 1'b1;
      end
    end else begin
      if (shadow_count > 0) begin
        r.addr = shadow_slots[0].addr;
        r.atype = shadow_slots[0].atype;
        r.prio = shadow_slots[0].prio;
        for (i = 1; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
        shadow_count--;
        r.ok = 1'b1;
      end
    end
    r.empty = (shadow_count == 0);
    r.full = (shadow_count >= QDEPTH);
    r.count = shadow_count[spq_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic step_t random_step(int unsigned insert_pct);
    step_t       s;
    logic [63:0] wide;
    s.func = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                  : spq_pkg::FUNC_REMOVE;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: s.item.addr = '1;
      1: s.item.addr = '0;
      default: s.item.addr = wide[spq_pkg::ADDR_W-1:0];
    endcase
    s.item.atype = spq_pkg::TYPE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: s.item.prio = PRIO_MAX;
      1: s.item.prio = PRIO_MIN;
      2, 3: s.item.prio = 64'($urandom_range(0, 8)) - 64'd4;
      default: s.item.prio = {$urandom, $urandom};
    endcase
    s.fixed = 1'b0;
    s.fixed_reply = '0;
    return s;
  endfunction

  function automatic int unsigned idle_burst(bit quiet);
    if (!quiet && $urandom_range(0, 5) == 0) return $urandom_range(1, 9);
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic issue(input step_t s, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= s.func;
    in_peer_address <= s.item.addr;
    in_peer_address_type <= s.item.atype;
    in_priority_req <= s.item.prio;
    req_fixed <= s.fixed;
    req_fixed_reply <= s.fixed_reply;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    reply_t          want;
    reply_t          pred;
    spq_pkg::entry_t req_item;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = awaited_replies.pop_front();
          check_field("ok", out_ok, want.ok);
          check_field("address", out_address, want.addr);
          check_field("address_type", out_address_type, want.atype);
          check_field("priority", out_priority, want.prio);
          check_field("now_empty", out_now_empty, want.empty);
          check_field("now_full", out_now_full, want.full);
          check_field("entry_count", out_entry_count, want.count);
        end
      end
      if (start && !busy) begin
        req_item.addr = in_peer_address;
        req_item.atype = in_peer_address_type;
        req_item.prio = in_priority_req;
        pred = apply_queue_op(in_func, req_item);
        awaited_replies.push_back(req_fixed ? req_fixed_reply : pred);
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned insert_pct;
    logic signed [spq_pkg::PRIO_W-1:0] fill_prio [16];
    fill_prio = '{64'sd0, -64'sd1, 64'sd1, 64'sd5, 64'sd5, -64'sd1, PRIO_MAX, PRIO_MIN,
                  64'sd3, 64'sd0, PRIO_MAX, 64'sd2, -64'sd7, 64'sd5, 64'sd0, PRIO_MIN};
    insert_pct = 50;

    directed_rows[0] = make_step(spq_pkg::FUNC_REMOVE, '0, '0, '0, 1'b1,
                                 make_reply(1'b0, '0, '0, '0, 1'b1, 1'b0, 5'd0));
    directed_rows[1] = make_step(spq_pkg::FUNC_INSERT, '1, '1, PRIO_MAX, 1'b1,
                                 make_reply(1'b1, '0, '0, '0, 1'b0, 1'b0, 5'd1));
    directed_rows[2] = make_step(spq_pkg::FUNC_INSERT, '0, '0, PRIO_MIN, 1'b1,
                                 make_reply(1'b1, '0, '0, '0, 1'b0, 1'b0, 5'd2));
    directed_rows[3] = make_step(spq_pkg::FUNC_REMOVE, '0, '0, '0, 1'b1,
                                 make_reply(1'b1, '1, '1, PRIO_MAX, 1'b0, 1'b0, 5'd1));
    // A tie with a lone front entry must queue behind it.
    directed_rows[4] = make_step(spq_pkg::FUNC_INSERT, 48'h1, 8'h01, PRIO_MIN, 1'b0, '0);
    directed_rows[5] = make_step(spq_pkg::FUNC_REMOVE, '0, '0, '0, 1'b0, '0);
    directed_rows[6] = make_step(spq_pkg::FUNC_REMOVE, '0, '0, '0, 1'b0, '0);
    directed_rows[7] = make_step(spq_pkg::FUNC_REMOVE, '1, '1, PRIO_MAX, 1'b1,
                                 make_reply(1'b0, '0, '0, '0, 1'b1, 1'b0, 5'd0));
    for (k = 0; k < 16; k++) begin
      directed_rows[8+k] = make_step(spq_pkg::FUNC_INSERT, 48'hA5A5_0000_0000 + 48'(k),
                                     8'h80 + k[7:0], fill_prio[k], 1'b0, '0);
    end
    directed_rows[24] = make_step(spq_pkg::FUNC_INSERT, 48'h5A5A_5A5A_5A5A, 8'h5A, 64'sd9,
                                  1'b1, make_reply(1'b0, '0, '0, '0, 1'b0, 1'b1, 5'd16));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++) issue(directed_rows[k], idle_burst(1'b0));

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 48 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      issue(random_step(insert_pct), idle_burst(k >= RAND_ITEMS - QUIET_TAIL));
    end
    start <= 1'b0;

    k = 0;
    while (awaited_replies.size() != 0 && k < 1000) begin
      @(posedge clk);
      k++;
    end
    repeat (4) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
test/tb_sorted_priority_queue.sv
